// ===== rtl/gnfp_pkg.sv =====
// ----------------------------------------------------------------------------
// gnfp_pkg
// shared constants, codes and record types of the navigation frame parser
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gnfp_pkg;

  // frame layout
  localparam int PayloadLen   = 92;
  localparam int PayloadStart = 6;
  localparam int PosW         = 7;

  localparam logic [PosW-1:0] PosSync1   = PosW'(0);
  localparam logic [PosW-1:0] PosSync2   = PosW'(1);
  localparam logic [PosW-1:0] PosClass   = PosW'(2);
  localparam logic [PosW-1:0] PosId      = PosW'(3);
  localparam logic [PosW-1:0] PosLenLo   = PosW'(4);
  localparam logic [PosW-1:0] PosLenHi   = PosW'(5);
  localparam logic [PosW-1:0] PosPayload = PosW'(PayloadStart);
  localparam logic [PosW-1:0] PosCkA     = PosW'(PayloadStart + PayloadLen);

  // header bytes
  localparam logic [7:0] Sync1    = 8'hB5;
  localparam logic [7:0] Sync2    = 8'h62;
  localparam logic [7:0] NavClass = 8'h01;
  localparam logic [7:0] PvtId    = 8'h07;

  // payload offsets of the captured fields
  localparam logic [PosW-1:0] OffYearLo = PosW'(4);
  localparam logic [PosW-1:0] OffYearHi = PosW'(5);
  localparam logic [PosW-1:0] OffMonth  = PosW'(6);
  localparam logic [PosW-1:0] OffDay    = PosW'(7);
  localparam logic [PosW-1:0] OffHour   = PosW'(8);
  localparam logic [PosW-1:0] OffMinute = PosW'(9);
  localparam logic [PosW-1:0] OffSecond = PosW'(10);
  localparam logic [PosW-1:0] OffValid  = PosW'(11);
  localparam logic [PosW-1:0] OffFix    = PosW'(20);
  localparam logic [PosW-1:0] OffSats   = PosW'(23);
  localparam logic [PosW-1:0] OffLon    = PosW'(24);
  localparam logic [PosW-1:0] OffLat    = PosW'(28);

  // validity flag bit for resolved time
  localparam int TimeResolvedBit = 2;

  localparam logic [7:0] MinFixReset = 8'd2;

  typedef enum logic [1:0] {
    ST_NONE     = 2'd0,
    ST_COMMIT   = 2'd1,
    ST_BAD_SUM  = 2'd2,
    ST_WEAK_FIX = 2'd3
  } frame_status_t;

  typedef struct packed {
    logic [15:0]        year;
    logic [7:0]         month;
    logic [7:0]         day;
    logic [7:0]         hour;
    logic [7:0]         minute;
    logic [7:0]         second;
    logic [7:0]         valid_flags;
    logic [7:0]         fix_type;
    logic [7:0]         num_sats;
    logic signed [31:0] longitude;
    logic signed [31:0] latitude;
  } nav_rec_t;

  // framer to record stage, one per accepted word
  typedef struct packed {
    frame_status_t status;
    logic          commit;
    nav_rec_t      shadow;
  } frm_res_t;

endpackage

`default_nettype wire

// ===== rtl/gnfp_if.sv =====
// ----------------------------------------------------------------------------
// gnfp_if
// valid/ready channels of the navigation frame parser
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface gnfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface gnfp_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         frame_status;
  logic               time_resolved;
  logic [15:0]        year;
  logic [7:0]         month;
  logic [7:0]         day;
  logic [7:0]         hour;
  logic [7:0]         minute;
  logic [7:0]         second;
  logic [7:0]         fix_type;
  logic [7:0]         num_sats;
  logic signed [31:0] longitude;
  logic signed [31:0] latitude;

  modport source (
    output valid, output frame_status, output time_resolved, output year,
    output month, output day, output hour, output minute, output second,
    output fix_type, output num_sats, output longitude, output latitude,
    input ready
  );
  modport sink (
    input valid, input frame_status, input time_resolved, input year,
    input month, input day, input hour, input minute, input second,
    input fix_type, input num_sats, input longitude, input latitude,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/gnfp_framer.sv =====
// ----------------------------------------------------------------------------
// gnfp_framer
// frame position tracking, fletcher sum, shadow capture and frame verdict
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gnfp_framer (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              acc,
  input  wire logic [7:0]        rx_byte,
  input  wire logic [7:0]        min_fix,
  output gnfp_pkg::frm_res_t     res
);

  logic [gnfp_pkg::PosW-1:0] pos_r, pos_nxt;
  logic [7:0]                len_lo_r, len_lo_nxt;
  logic [7:0]                sum_a_r, sum_a_nxt;
  logic [7:0]                sum_b_r, sum_b_nxt;
  logic [7:0]                rx_sum_a_r, rx_sum_a_nxt;
  gnfp_pkg::nav_rec_t        shadow_r, shadow_nxt;

  logic [gnfp_pkg::PosW-1:0] off;
  logic [7:0]                add_a, add_b;
  gnfp_pkg::frame_status_t   status;

  assign off   = pos_r - gnfp_pkg::PosPayload;
  assign add_a = sum_a_r + rx_byte;
  assign add_b = sum_b_r + add_a;

  always_comb begin
    pos_nxt      = gnfp_pkg::PosSync1;
    len_lo_nxt   = len_lo_r;
    sum_a_nxt    = sum_a_r;
    sum_b_nxt    = sum_b_r;
    rx_sum_a_nxt = rx_sum_a_r;
    shadow_nxt   = shadow_r;
    status       = gnfp_pkg::ST_NONE;

    if (pos_r == gnfp_pkg::PosSync1) begin
      if (rx_byte == gnfp_pkg::Sync1) pos_nxt = gnfp_pkg::PosSync2;
    end else if (pos_r == gnfp_pkg::PosSync2) begin
      if (rx_byte == gnfp_pkg::Sync2) pos_nxt = gnfp_pkg::PosClass;
    end else if (pos_r == gnfp_pkg::PosClass) begin
      // sum restarts on the class byte
      if (rx_byte == gnfp_pkg::NavClass) begin
        sum_a_nxt = rx_byte;
        sum_b_nxt = rx_byte;
        pos_nxt   = gnfp_pkg::PosId;
      end
    end else if (pos_r == gnfp_pkg::PosId) begin
      if (rx_byte == gnfp_pkg::PvtId) begin
        sum_a_nxt = add_a;
        sum_b_nxt = add_b;
        pos_nxt   = gnfp_pkg::PosLenLo;
      end
    end else if (pos_r == gnfp_pkg::PosLenLo) begin
      len_lo_nxt = rx_byte;
      sum_a_nxt  = add_a;
      sum_b_nxt  = add_b;
      pos_nxt    = gnfp_pkg::PosLenHi;
    end else if (pos_r == gnfp_pkg::PosLenHi) begin
      sum_a_nxt = add_a;
      sum_b_nxt = add_b;
      if ({rx_byte, len_lo_r} == 16'(gnfp_pkg::PayloadLen)) pos_nxt = gnfp_pkg::PosPayload;
    end else if (pos_r < gnfp_pkg::PosCkA) begin
      sum_a_nxt = add_a;
      sum_b_nxt = add_b;
      pos_nxt   = pos_r + gnfp_pkg::PosW'(1);
      case (off) inside
        gnfp_pkg::OffYearLo: shadow_nxt.year[7:0]   = rx_byte;
        gnfp_pkg::OffYearHi: shadow_nxt.year[15:8]  = rx_byte;
        gnfp_pkg::OffMonth:  shadow_nxt.month       = rx_byte;
        gnfp_pkg::OffDay:    shadow_nxt.day         = rx_byte;
        gnfp_pkg::OffHour:   shadow_nxt.hour        = rx_byte;
        gnfp_pkg::OffMinute: shadow_nxt.minute      = rx_byte;
        gnfp_pkg::OffSecond: shadow_nxt.second      = rx_byte;
        gnfp_pkg::OffValid:  shadow_nxt.valid_flags = rx_byte;
        gnfp_pkg::OffFix:    shadow_nxt.fix_type    = rx_byte;
        gnfp_pkg::OffSats:   shadow_nxt.num_sats    = rx_byte;
        [gnfp_pkg::OffLon:gnfp_pkg::OffLon + gnfp_pkg::PosW'(3)]:
          shadow_nxt.longitude[8*off[1:0] +: 8] = rx_byte;
        [gnfp_pkg::OffLat:gnfp_pkg::OffLat + gnfp_pkg::PosW'(3)]:
          shadow_nxt.latitude[8*off[1:0] +: 8] = rx_byte;
        default: ;
      endcase
    end else if (pos_r == gnfp_pkg::PosCkA) begin
      rx_sum_a_nxt = rx_byte;
      pos_nxt      = gnfp_pkg::PosCkA + gnfp_pkg::PosW'(1);
    end else begin
      // second checksum byte: frame verdict
      if (rx_sum_a_r != sum_a_r || rx_byte != sum_b_r) begin
        status = gnfp_pkg::ST_BAD_SUM;
      end else if (shadow_r.fix_type < min_fix) begin
        status = gnfp_pkg::ST_WEAK_FIX;
      end else begin
        status = gnfp_pkg::ST_COMMIT;
      end
    end
  end

  assign res.status = status;
  assign res.commit = (status == gnfp_pkg::ST_COMMIT);
  assign res.shadow = shadow_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= gnfp_pkg::PosSync1;
      len_lo_r   <= '0;
      sum_a_r    <= '0;
      sum_b_r    <= '0;
      rx_sum_a_r <= '0;
    end else if (acc) begin
      pos_r      <= pos_nxt;
      len_lo_r   <= len_lo_nxt;
      sum_a_r    <= sum_a_nxt;
      sum_b_r    <= sum_b_nxt;
      rx_sum_a_r <= rx_sum_a_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) shadow_r <= shadow_nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/gnfp_record.sv =====
// ----------------------------------------------------------------------------
// gnfp_record
// committed record and result register with its valid flag
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gnfp_record (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    acc,
  input  wire gnfp_pkg::frm_res_t      res,
  input  wire logic                    out_ready,
  output logic                         out_valid,
  output gnfp_pkg::frame_status_t      status,
  output gnfp_pkg::nav_rec_t           rec
);

  logic                    out_valid_r, out_valid_nxt;
  gnfp_pkg::frame_status_t status_r;
  gnfp_pkg::nav_rec_t      rec_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (acc) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // committed record doubles as result payload: it only moves on accept
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      status_r    <= gnfp_pkg::ST_NONE;
      rec_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (acc) begin
        status_r <= res.status;
        if (res.commit) rec_r <= res.shadow;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign status    = status_r;
  assign rec       = rec_r;

endmodule

`default_nettype wire

// ===== rtl/gnss_nav_frame_parser.sv =====
// ----------------------------------------------------------------------------
// gnss_nav_frame_parser
// byte-wise navigation frame parser with checksum check and record commit
// ----------------------------------------------------------------------------
//  channel   dir  payload                                      handshake
//  in_ch     in   rx_byte                                      valid/ready
//  out_ch    out  frame_status, committed time/fix/position    valid/ready
//  cfg_*     in   min_fix_type                                 write enable
//
//  one word per cycle while the result register is free or drains: a word
//  accepted at an edge has its result registered in the output register; the path is framer logic into that register
//  in_ch.ready = no result held or the held result is taken this cycle
//  a stalled result holds its word and the committed record together
//  synchronous active-low reset: hunting for sync, record zero, minimum fix 2
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gnss_nav_frame_parser (
  input  wire logic        clk,
  input  wire logic        rst_n,
  gnfp_in_if.sink          in_ch,
  gnfp_out_if.source       out_ch,
  input  wire logic        cfg_we,
  input  wire logic [7:0]  cfg_data
);

  // minimum fix type register
  logic [7:0]              min_fix_r;

  logic                    in_acc;
  logic                    out_valid;
  gnfp_pkg::frm_res_t      frm;
  gnfp_pkg::frame_status_t status;
  gnfp_pkg::nav_rec_t      rec;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_fix_r <= gnfp_pkg::MinFixReset;
    end else if (cfg_we) begin
      min_fix_r <= cfg_data;
    end
  end

  // a new word goes in whenever the result register is free or drains now
  assign in_ch.ready = !out_valid || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;

  // position, sums and shadow record
  gnfp_framer u_framer (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (in_acc),
    .rx_byte (in_ch.rx_byte),
    .min_fix (min_fix_r),
    .res     (frm)
  );

  // committed record and result register
  gnfp_record u_record (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (in_acc),
    .res       (frm),
    .out_ready (out_ch.ready),
    .out_valid (out_valid),
    .status    (status),
    .rec       (rec)
  );

  // result fields straight from the committed record
  assign out_ch.valid         = out_valid;
  assign out_ch.frame_status  = status;
  assign out_ch.time_resolved = rec.valid_flags[gnfp_pkg::TimeResolvedBit];
  assign out_ch.year          = rec.year;
  assign out_ch.month         = rec.month;
  assign out_ch.day           = rec.day;
  assign out_ch.hour          = rec.hour;
  assign out_ch.minute        = rec.minute;
  assign out_ch.second        = rec.second;
  assign out_ch.fix_type      = rec.fix_type;
  assign out_ch.num_sats      = rec.num_sats;
  assign out_ch.longitude     = rec.longitude;
  assign out_ch.latitude      = rec.latitude;

`ifndef SYNTHESIS
  // every accepted word shows up as a result with its status
  a_status_passed: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_ch.valid && out_ch.frame_status == $past(frm.status))
    else $error("result status does not match accepted word");

  // a commit happens only on a good frame verdict
  a_commit_good: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && frm.commit |-> frm.status == gnfp_pkg::ST_COMMIT)
    else $error("record committed without good verdict");

  // record holds when the word commits nothing
  a_rec_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !frm.commit |=> $stable(out_ch.latitude) && $stable(out_ch.year)
      && $stable(out_ch.fix_type))
    else $error("committed record moved without commit");

  // an empty result register never blocks the input
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_ch.valid |-> in_ch.ready)
    else $error("input stalled with empty result register");
`endif

endmodule

`default_nettype wire

// ===== bench/gnss_nav_frame_parser_test.sv =====
// ----------------------------------------------------------------------------
// gnss_nav_frame_parser_test
// self-checking bench for the byte-wise navigation frame parser: frames,
// broken headers, bad sums and weak fixes go in one word at a time, and every
// report coming out is compared field by field with a local frame predictor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gnss_nav_frame_parser_test;
  import gnfp_pkg::*;

  // kinds of byte sequence the stimulus can produce
  // the header-breaking kinds are kept consecutive, the random part indexes them
  typedef enum logic [3:0] {
    F_NOISE,
    F_GOOD,
    F_BAD_CKA,
    F_BAD_CKB,
    F_BAD_SYNC2,
    F_DOUBLE_SYNC,
    F_BAD_CLASS,
    F_BAD_ID,
    F_BAD_LEN_LO,
    F_BAD_LEN_HI,
    F_TRUNC,
    F_CFG
  } seq_kind_t;

  // one row of the directed table
  // fill is the payload byte (or the register value for a config row)
  // pos_ext 1: longitude min, latitude max; 2: the other way round
  typedef struct packed {
    seq_kind_t     kind;
    logic [7:0]    fix;
    logic [7:0]    flags;
    logic [7:0]    fill;
    logic          rand_fill;
    logic [1:0]    pos_ext;
    logic          has_exp;
    frame_status_t want_status;
  } stim_row_t;

  // everything the block reports for one word
  typedef struct packed {
    frame_status_t      status;
    logic               time_resolved;
    logic [15:0]        year;
    logic [7:0]         month;
    logic [7:0]         day;
    logic [7:0]         hour;
    logic [7:0]         minute;
    logic [7:0]         second;
    logic [7:0]         fix_type;
    logic [7:0]         num_sats;
    logic signed [31:0] longitude;
    logic signed [31:0] latitude;
  } nav_report_t;

  localparam int NumRows       = 13;
  localparam int NumPhases     = 2;
  localparam int PhaseWords    = 80;
  localparam int StallLimit    = 1000;
  localparam int ReportLimit   = 10;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [7:0] cfg_data;

  gnfp_in_if  in_ch ();
  gnfp_out_if out_ch ();

  gnss_nav_frame_parser DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  // 10 ns clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // predictor state: framer position, running fletcher sums, shadow and
  // committed records, and the local copy of the minimum fix register
  // --------------------------------------------------------------------------
  logic [PosW-1:0] frame_pos = PosSync1;
  logic [7:0]      len_lo    = 8'h00;
  logic [7:0]      sum_a     = 8'h00;
  logic [7:0]      sum_b     = 8'h00;
  logic [7:0]      got_sum_a = 8'h00;
  logic [7:0]      min_fix   = MinFixReset;
  nav_rec_t        shadow    = '0;
  nav_rec_t        committed = '0;

  nav_report_t   pending_reports [$];   // expected reports, oldest first
  frame_status_t pinned_status [int];   // table statuses, keyed by word number

  int  words_sent   = 0;   // words the sender got through
  int  reports_seen = 0;   // reports taken from the block
  int  fail_count   = 0;
  int  idle_cycles  = 0;
  int  stall_left   = 0;
  bit  calm         = 1'b0;   // no idling on either side when set
  logic [7:0] cfg_now = MinFixReset;

  stim_row_t directed_rows [NumRows];

  function automatic void fletcher_add(input logic [7:0] b);
    sum_a = sum_a + b;
    sum_b = sum_b + sum_a;
  endfunction

  // one received byte through the framer, returns the report it causes
  function automatic nav_report_t parse_nav_byte(input logic [7:0] b);
    nav_report_t     r;
    frame_status_t   st;
    logic [PosW-1:0] nxt;
    logic [PosW-1:0] off;
    st  = ST_NONE;
    nxt = PosSync1;   // any mismatch drops back to hunting
    if (frame_pos == PosSync1) begin
      if (b == Sync1) nxt = PosSync2;
    end else if (frame_pos == PosSync2) begin
      if (b == Sync2) nxt = PosClass;
    end else if (frame_pos == PosClass) begin
      if (b == NavClass) begin
        // sums restart on the class byte
        sum_a = 8'h00;
        sum_b = 8'h00;
        fletcher_add(b);
        nxt = PosId;
      end
    end else if (frame_pos == PosId) begin
      if (b == PvtId) begin
        fletcher_add(b);
        nxt = PosLenLo;
      end
    end else if (frame_pos == PosLenLo) begin
      len_lo = b;
      fletcher_add(b);
      nxt = PosLenHi;
    end else if (frame_pos == PosLenHi) begin
      fletcher_add(b);
      if ({b, len_lo} == 16'(PayloadLen)) nxt = PosPayload;
    end else if (frame_pos < PosCkA) begin
      fletcher_add(b);
      off = frame_pos - PosPayload;
      case (off)
        OffYearLo: shadow.year[7:0]    = b;
        OffYearHi: shadow.year[15:8]   = b;
        OffMonth:  shadow.month        = b;
        OffDay:    shadow.day          = b;
        OffHour:   shadow.hour         = b;
        OffMinute: shadow.minute       = b;
        OffSecond: shadow.second       = b;
        OffValid:  shadow.valid_flags  = b;
        OffFix:    shadow.fix_type     = b;
        OffSats:   shadow.num_sats     = b;
        default: begin
          // position words are little endian
          if (off >= OffLon && off < OffLon + 4)
            shadow.longitude[8*(off - OffLon) +: 8] = b;
          else if (off >= OffLat && off < OffLat + 4)
            shadow.latitude[8*(off - OffLat) +: 8] = b;
        end
      endcase
      nxt = frame_pos + 1'b1;
    end else if (frame_pos == PosCkA) begin
      got_sum_a = b;
      nxt = PosCkA + 1'b1;
    end else begin
      // second checksum byte: a bad sum wins over a weak fix
      if (got_sum_a != sum_a || b != sum_b) st = ST_BAD_SUM;
      else if (shadow.fix_type < min_fix) st = ST_WEAK_FIX;
      else begin
        committed = shadow;
        st = ST_COMMIT;
      end
    end
    frame_pos = nxt;

    r.status        = st;
    r.time_resolved = committed.valid_flags[TimeResolvedBit];
    r.year          = committed.year;
    r.month         = committed.month;
    r.day           = committed.day;
    r.hour          = committed.hour;
    r.minute        = committed.minute;
    r.second        = committed.second;
    r.fix_type      = committed.fix_type;
    r.num_sats      = committed.num_sats;
    r.longitude     = committed.longitude;
    r.latitude      = committed.latitude;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // checking
  // --------------------------------------------------------------------------
  task automatic note_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    fail_count++;
    if (fail_count <= ReportLimit)
      $display("word %0d %s: expected %0h, got %0h", reports_seen, what, want, got);
  endtask

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) note_mismatch(what, want, got);
  endtask

  task automatic compare_report(input nav_report_t want);
    check_field("frame_status",  32'(want.status),        32'(out_ch.frame_status));
    check_field("time_resolved", 32'(want.time_resolved), 32'(out_ch.time_resolved));
    check_field("year",          32'(want.year),          32'(out_ch.year));
    check_field("month",         32'(want.month),         32'(out_ch.month));
    check_field("day",           32'(want.day),           32'(out_ch.day));
    check_field("hour",          32'(want.hour),          32'(out_ch.hour));
    check_field("minute",        32'(want.minute),        32'(out_ch.minute));
    check_field("second",        32'(want.second),        32'(out_ch.second));
    check_field("fix_type",      32'(want.fix_type),      32'(out_ch.fix_type));
    check_field("num_sats",      32'(want.num_sats),      32'(out_ch.num_sats));
    check_field("longitude",     want.longitude,          out_ch.longitude);
    check_field("latitude",      want.latitude,           out_ch.latitude);
  endtask

  // monitor: everything is sampled at the rising edge, before the block's
  // own registers move, so an accepted word is exactly valid && ready here
  always @(posedge clk) begin : monitor
    nav_report_t want;
    bit          moved;
    moved = 1'b0;
    if (rst_n) begin
      if (cfg_we) min_fix = cfg_data;
      if (in_ch.valid && in_ch.ready) begin
        want = parse_nav_byte(in_ch.rx_byte);
        pending_reports.push_back(want);
        moved = 1'b1;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (pending_reports.size() == 0) begin
          fail_count++;
          if (fail_count <= ReportLimit)
            $display("word %0d: report with nothing expected", reports_seen);
        end else begin
          compare_report(pending_reports.pop_front());
        end
        // directed rows also carry an expected status taken from the table
        if (pinned_status.exists(reports_seen) &&
            out_ch.frame_status !== pinned_status[reports_seen])
          note_mismatch("table frame_status", 32'(pinned_status[reports_seen]),
                        32'(out_ch.frame_status));
        reports_seen++;
        moved = 1'b1;
      end
      // watchdog: nothing moving on either channel for too long
      if (moved) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("no word moved for %0d cycles", StallLimit);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // receiver side: random stall bursts, none once calm
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 6);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // sender side
  // --------------------------------------------------------------------------

  // offer one word, sometimes after a gap, and hold it until it is taken
  task automatic push_word(input logic [7:0] b);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    words_sent++;
  endtask

  // stop sending and wait until every expected report has come out
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic set_min_fix(input logic [7:0] v);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    cfg_now  = v;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  // build one frame around rec, damage it as kind says, and send it
  // pause_at >= 0 drains all results before that byte of the frame
  task automatic send_frame(input seq_kind_t kind, input nav_rec_t rec,
                            input bit rand_fill, input logic [7:0] fill,
                            input int pause_at, input bit has_exp,
                            input frame_status_t want_status);
    logic [7:0] pl [PayloadLen];
    logic [7:0] body [$];
    logic [7:0] bytes_out [$];
    logic [7:0] ck_a;
    logic [7:0] ck_b;
    logic [7:0] nz;
    nz = 8'($urandom_range(1, 255));
    for (int i = 0; i < PayloadLen; i++) pl[i] = rand_fill ? 8'($urandom) : fill;
    pl[OffYearLo] = rec.year[7:0];
    pl[OffYearHi] = rec.year[15:8];
    pl[OffMonth]  = rec.month;
    pl[OffDay]    = rec.day;
    pl[OffHour]   = rec.hour;
    pl[OffMinute] = rec.minute;
    pl[OffSecond] = rec.second;
    pl[OffValid]  = rec.valid_flags;
    pl[OffFix]    = rec.fix_type;
    pl[OffSats]   = rec.num_sats;
    for (int k = 0; k < 4; k++) begin
      pl[OffLon + k] = rec.longitude[8*k +: 8];
      pl[OffLat + k] = rec.latitude[8*k +: 8];
    end

    // summed part: class, id, length, payload
    body = {NavClass, PvtId, 8'(PayloadLen), 8'(PayloadLen >> 8)};
    for (int i = 0; i < PayloadLen; i++) body.push_back(pl[i]);
    ck_a = 8'h00;
    ck_b = 8'h00;
    foreach (body[i]) begin
      ck_a = ck_a + body[i];
      ck_b = ck_b + ck_a;
    end

    case (kind)
      F_BAD_CLASS:  body[0] = body[0] ^ nz;
      F_BAD_ID:     body[1] = body[1] ^ nz;
      F_BAD_LEN_LO: body[2] = body[2] ^ nz;
      F_BAD_LEN_HI: body[3] = body[3] ^ nz;
      F_BAD_CKA:    ck_a = ck_a ^ nz;
      F_BAD_CKB:    ck_b = ck_b ^ nz;
      default: ;
    endcase

    bytes_out = {Sync1, Sync2};
    foreach (body[i]) bytes_out.push_back(body[i]);
    bytes_out.push_back(ck_a);
    bytes_out.push_back(ck_b);
    if (kind == F_BAD_SYNC2) bytes_out[1] = Sync2 ^ nz;
    // a repeated first sync byte loses the frame, it is not a fresh start
    if (kind == F_DOUBLE_SYNC) bytes_out.push_front(Sync1);
    // a broken header ends the sequence, the block is back to hunting
    if (kind >= F_BAD_SYNC2 && kind <= F_BAD_LEN_HI) begin
      while (bytes_out.size() > ((kind == F_DOUBLE_SYNC) ? 7 : 6))
        void'(bytes_out.pop_back());
    end
    if (kind == F_TRUNC) begin
      repeat (bytes_out.size() - $urandom_range(3, 99)) void'(bytes_out.pop_back());
    end

    foreach (bytes_out[i]) begin
      if (i == pause_at) drain_results();
      if (has_exp && i == bytes_out.size() - 1) pinned_status[words_sent] = want_status;
      push_word(bytes_out[i]);
    end
  endtask

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    nav_rec_t   rec;
    seq_kind_t  kind;
    logic [7:0] fix;
    logic [7:0] phase_fix;
    int         pick;
    int         start_words;
    int         pause_at;

    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.rx_byte <= 8'h00;
    cfg_we        <= 1'b0;
    cfg_data      <= 8'h00;

    //                kind           fix    flags  fill  rnd ext exp  status
    directed_rows = '{
      '{F_NOISE,       8'h00, 8'h00, 8'h00, 1'b0, 2'd0, 1'b1, ST_NONE},
      '{F_NOISE,       8'h00, 8'h00, 8'hFF, 1'b0, 2'd0, 1'b1, ST_NONE},
      '{F_GOOD,        8'h03, 8'h04, 8'h00, 1'b0, 2'd1, 1'b1, ST_COMMIT},
      '{F_GOOD,        8'h01, 8'h04, 8'h00, 1'b1, 2'd0, 1'b1, ST_WEAK_FIX},
      '{F_BAD_CKA,     8'h00, 8'h04, 8'h00, 1'b1, 2'd0, 1'b1, ST_BAD_SUM},
      '{F_BAD_SYNC2,   8'h03, 8'h04, 8'h00, 1'b1, 2'd0, 1'b1, ST_NONE},
      '{F_DOUBLE_SYNC, 8'h03, 8'h04, 8'h00, 1'b1, 2'd0, 1'b1, ST_NONE},
      '{F_BAD_CLASS,   8'h03, 8'h04, 8'h00, 1'b1, 2'd0, 1'b1, ST_NONE},
      '{F_BAD_ID,      8'h03, 8'h04, 8'h00, 1'b1, 2'd0, 1'b1, ST_NONE},
      '{F_BAD_LEN_LO,  8'h03, 8'h04, 8'h00, 1'b1, 2'd0, 1'b1, ST_NONE},
      '{F_BAD_LEN_HI,  8'h03, 8'h04, 8'h00, 1'b1, 2'd0, 1'b1, ST_NONE},
      '{F_CFG,         8'h00, 8'h00, 8'hFF, 1'b0, 2'd0, 1'b0, ST_NONE},
      '{F_GOOD,        8'hFF, 8'hFB, 8'hFF, 1'b0, 2'd2, 1'b1, ST_COMMIT}
    };

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed part: reset state, field extremes, every frame outcome and
    // every way a header can break
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == F_CFG) begin
        drain_results();
        set_min_fix(directed_rows[i].fill);
      end else if (directed_rows[i].kind == F_NOISE) begin
        if (directed_rows[i].has_exp)
          pinned_status[words_sent] = directed_rows[i].want_status;
        push_word(directed_rows[i].fill);
      end else begin
        rec = {18{directed_rows[i].fill}};
        if (directed_rows[i].rand_fill)
          rec = {$urandom, $urandom, $urandom, $urandom, 16'($urandom)};
        rec.fix_type    = directed_rows[i].fix;
        rec.valid_flags = directed_rows[i].flags;
        if (directed_rows[i].pos_ext == 2'd1) begin
          rec.longitude = 32'sh8000_0000;
          rec.latitude  = 32'sh7FFF_FFFF;
        end else if (directed_rows[i].pos_ext == 2'd2) begin
          rec.longitude = 32'sh7FFF_FFFF;
          rec.latitude  = 32'sh8000_0000;
        end
        send_frame(directed_rows[i].kind, rec, directed_rows[i].rand_fill,
                   directed_rows[i].fill, -1, directed_rows[i].has_exp,
                   directed_rows[i].want_status);
      end
    end

    // random part: one phase at a random minimum fix setting, one at the reset
    // value, each running until it has sent its share of words; last one calm
    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0:       phase_fix = 8'($urandom_range(0, 5));
        default: phase_fix = MinFixReset;
      endcase
      drain_results();
      set_min_fix(phase_fix);
      calm = (p == NumPhases - 1);
      start_words = words_sent;
      while (words_sent - start_words < PhaseWords) begin
        pick = $urandom_range(0, 99);
        if (pick >= 88) begin
          // line noise, now and then a lone first sync byte
          repeat ($urandom_range(1, 8))
            push_word(($urandom_range(0, 3) == 0) ? Sync1 : 8'($urandom));
        end else begin
          // fix codes mostly near the threshold, where the decision flips
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: fix = 8'($urandom_range(0, 5));
            5, 6, 7:       fix = cfg_now + 8'($urandom_range(0, 2)) - 8'd1;
            8:             fix = 8'hFF;
            default:       fix = 8'($urandom);
          endcase
          if (pick < 55) kind = F_GOOD;
          else if (pick < 60) kind = F_BAD_CKA;
          else if (pick < 65) kind = F_BAD_CKB;
          else if (pick < 80) kind = seq_kind_t'(4'(int'(F_BAD_SYNC2) + $urandom_range(0, 5)));
          else kind = F_TRUNC;
          rec = {$urandom, $urandom, $urandom, $urandom, 16'($urandom)};
          rec.fix_type = fix;
          // occasionally hold the sender mid-frame until the pipe is empty
          pause_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 99) : -1;
          case ($urandom_range(0, 7))
            0:       send_frame(kind, rec, 1'b0, 8'h00, pause_at, 1'b0, ST_NONE);
            1:       send_frame(kind, rec, 1'b0, 8'hFF, pause_at, 1'b0, ST_NONE);
            default: send_frame(kind, rec, 1'b1, 8'h00, pause_at, 1'b0, ST_NONE);
          endcase
        end
      end
    end

    drain_results();
    if (pending_reports.size() != 0) begin
      fail_count += pending_reports.size();
      $display("%0d reports never came out", pending_reports.size());
    end
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
